>>> hdl/cds_pkg.sv
// Package with shared types and constants for the critically damped smoother.
`default_nettype none
package cds_pkg;
  localparam int unsigned WideW = 64;
  localparam logic [31:0] MinSmooth = 32'd7;
  localparam logic [15:0] C048 = 16'd31457;
  localparam logic [15:0] C0235 = 16'd15401;
  localparam logic [63:0] XLimit = 64'd8388608;
  localparam logic signed [63:0] WideMax = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic [0:0] RegSmoothTime = 1'd0;
  localparam logic [0:0] RegMaxSpeed = 1'd1;

  // Operation codes for the shared multiply/divide unit.
  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } cds_op_t;

  typedef struct packed {
    logic    start;
    cds_op_t op;
  } cds_cmd_t;
endpackage
`default_nettype wire

>>> hdl/cds_alu.sv
// Shared iterative unit: signed Q16.16 multiply or unsigned 64-bit divide.
`default_nettype none
module cds_alu (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cds_pkg::cds_cmd_t   cmd,
  input  wire logic signed [63:0]  op_a,
  input  wire logic signed [63:0]  op_b,
  output logic                     done,
  output logic signed [63:0]       result
);
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic         neg_r, neg_nxt;
  logic         is_div_r, is_div_nxt;
  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [64:0]  rem_sh;
  logic [63:0]  mag_a, mag_b;
  logic [127:0] prod_sh;
  logic [63:0]  q_mag;

  assign mag_a = op_a[63] ? 64'(-op_a) : 64'(op_a);
  assign mag_b = op_b[63] ? 64'(-op_b) : 64'(op_b);
  assign rem_sh = {acc_r[127:64], a_r[63]};
  assign prod_sh = acc_r >> 16;

  // Multiply adds one bit of b per cycle; divide restores one quotient bit per cycle.
  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt = neg_r;
    is_div_nxt = is_div_r;
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd64;
      acc_nxt = '0;
      is_div_nxt = (cmd.op == cds_pkg::OP_DIV);
      if (cmd.op == cds_pkg::OP_DIV) begin
        a_nxt = 64'(op_a);
        b_nxt = 64'(op_b);
        neg_nxt = 1'b0;
      end else begin
        a_nxt = mag_a;
        b_nxt = mag_b;
        neg_nxt = op_a[63] ^ op_b[63];
      end
    end else if (busy_r) begin
      if (is_div_r) begin
        if (rem_sh >= {1'b0, b_r}) begin
          acc_nxt[127:64] = 64'(rem_sh - {1'b0, b_r});
          acc_nxt[63:0] = {acc_r[62:0], 1'b1};
        end else begin
          acc_nxt[127:64] = rem_sh[63:0];
          acc_nxt[63:0] = {acc_r[62:0], 1'b0};
        end
        a_nxt = {a_r[62:0], 1'b0};
      end else begin
        a_nxt = a_r;
        b_nxt = {1'b0, b_r[63:1]};
        acc_nxt = b_r[0] ? (acc_r + ({64'd0, a_r} << (7'd64 - cnt_r)))
                         : acc_r;
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    is_div_r <= is_div_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  // Saturate the multiply magnitude to the wide limit, then apply the sign.
  // A full product that does not fit in 64 bits also saturates.
  always_comb begin
    if ((acc_r[127:64] != '0) || (prod_sh[63:62] != '0)) q_mag = 64'(cds_pkg::WideMax);
    else q_mag = prod_sh[63:0];
    if (is_div_r) result = signed'(acc_r[63:0]);
    else result = neg_r ? -signed'(q_mag) : signed'(q_mag);
  end

  assign done = done_r;
endmodule
`default_nettype wire

>>> hdl/critically_damped_smoother.sv
// Top level of the critically damped smoother.
// Each item runs through a sequence of thirteen operations on one shared unit
// that multiplies or divides one bit per cycle; each operation is issued,
// iterates over the operand bits and has its result stored before the next
// one is issued. The block accepts the next item once the result has been
// taken. Velocity is kept between items.
`default_nettype none
module critically_damped_smoother (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_current_value,
  input  wire logic signed [31:0] in_target_value,
  input  wire logic [31:0]        in_step_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_next_value,
  output logic signed [31:0]      out_next_velocity,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_FIN = 4'b1000
  } state_t;

  typedef logic signed [63:0] wide_t;

  state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [31:0] smooth_r, speed_r;
  logic signed [31:0] vel_r;
  wide_t cur_r, tgt_r, dt_r, st_r;
  wide_t w_r, x_r, x2_r, den_r, d_r, err_r, t_r, tmp_r;
  wide_t res, op_a, op_b;
  logic out_valid_r;
  logic signed [31:0] onx_r, onv_r;
  cds_pkg::cds_cmd_t cmd;
  logic alu_done;

  cds_alu u_alu (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .op_a(op_a), .op_b(op_b),
    .done(alu_done), .result(res)
  );

  function automatic wide_t wclamp(input logic signed [64:0] v);
    if (v > 65'(cds_pkg::WideMax)) return cds_pkg::WideMax;
    if (v < -65'(cds_pkg::WideMax)) return -cds_pkg::WideMax;
    return wide_t'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Operand selection per sequence step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    cmd.start = (state_r == ST_ISSUE);
    cmd.op = cds_pkg::OP_MUL;
    unique case (step_r)
      4'd0: begin op_a = 64'sh2_0000_0000; op_b = st_r; cmd.op = cds_pkg::OP_DIV; end
      4'd1: begin op_a = w_r; op_b = dt_r; end
      4'd2: begin op_a = x_r; op_b = x_r; end
      4'd3: begin op_a = x2_r; op_b = x_r; end
      4'd4: begin op_a = 64'(cds_pkg::C048); op_b = x2_r; end
      4'd5: begin op_a = 64'(cds_pkg::C0235); op_b = tmp_r; end
      4'd6: begin op_a = 64'sh1_0000_0000; op_b = den_r; cmd.op = cds_pkg::OP_DIV; end
      4'd7: begin op_a = 64'(speed_r); op_b = st_r; end
      4'd8: begin op_a = w_r; op_b = err_r; end
      4'd9: begin op_a = tmp_r; op_b = dt_r; end
      4'd10: begin op_a = w_r; op_b = t_r; end
      4'd11: begin op_a = tmp_r; op_b = d_r; end
      4'd12: begin op_a = wclamp(65'(err_r) + 65'(t_r)); op_b = d_r; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;

  // Sequencer: issue, wait, store result, move to the next step.
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready) begin
        state_nxt = ST_ISSUE;
        step_nxt = '0;
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: if (alu_done) begin
        if (step_r == 4'd12) state_nxt = ST_FIN;
        else begin
          state_nxt = ST_ISSUE;
          step_nxt = step_r + 4'd1;
        end
      end
      ST_FIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  wide_t e_raw, nx_v;
  logic snap;
  always_comb begin
    e_raw = cur_r - tgt_r;
    nx_v = wclamp(65'(cur_r - err_r) + 65'(res));
    snap = ((tgt_r - cur_r) > 0) == (nx_v > tgt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      smooth_r <= 32'd65536;
      speed_r <= 32'hFFFF_FFFF;
      vel_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      if (cfg_we) begin
        if (cfg_index == cds_pkg::RegSmoothTime) smooth_r <= cfg_data;
        else speed_r <= cfg_data;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_WAIT && alu_done && step_r == 4'd12) begin
        out_valid_r <= 1'b1;
        vel_r <= snap ? 32'sd0 : sat32(tmp_r);
      end
    end
    if (state_r == ST_IDLE && in_valid && in_ready) begin
      cur_r <= 64'(in_current_value);
      tgt_r <= 64'(in_target_value);
      dt_r <= 64'({32'd0, in_step_time});
      st_r <= (smooth_r < cds_pkg::MinSmooth) ? 64'(cds_pkg::MinSmooth)
                                              : 64'({32'd0, smooth_r});
    end
    // Store each step's result where the next steps need it.
    if (state_r == ST_WAIT && alu_done) begin
      unique case (step_r)
        4'd0: w_r <= res;
        4'd1: x_r <= (res > signed'(cds_pkg::XLimit)) ? signed'(cds_pkg::XLimit) : res;
        4'd2: x2_r <= res;
        4'd3: tmp_r <= res;
        4'd4: den_r <= 64'sd65536 + x_r + res;
        4'd5: den_r <= den_r + res;
        4'd6: d_r <= res;
        4'd7: begin
          if (e_raw > res) err_r <= res;
          else if (e_raw < -res) err_r <= -res;
          else err_r <= e_raw;
        end
        4'd8: tmp_r <= wclamp(65'(vel_r) + 65'(res));
        4'd9: t_r <= res;
        4'd10: tmp_r <= wclamp(65'(vel_r) - 65'(res));
        4'd11: tmp_r <= res;
        4'd12: begin
          onx_r <= snap ? tgt_r[31:0] : sat32(nx_v);
          onv_r <= snap ? 32'sd0 : sat32(tmp_r);
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_next_value = onx_r;
  assign out_next_velocity = onv_r;
endmodule
`default_nettype wire

>>> tb/sv/critically_damped_smoother_tb.sv
// Self-checking testbench for the critically damped smoother top level.
`default_nettype none
module critically_damped_smoother_tb;
  localparam int unsigned LatencyCycles = 1200;
  localparam longint unsigned CycleLimit = 64'd6_000_000;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] velocity;
  } smooth_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_current_value = '0;
  logic signed [31:0] in_target_value = '0;
  logic [31:0] in_step_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_next_value;
  logic signed [31:0] out_next_velocity;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor state: register copies and the kept velocity.
  logic [31:0] smooth_time_q = 32'd65536;
  logic [31:0] max_speed_q = 32'hFFFF_FFFF;
  logic signed [31:0] velocity_q = '0;

  smooth_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint unsigned cycle_count = 0;

  critically_damped_smoother u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_current_value(in_current_value), .in_target_value(in_target_value),
    .in_step_time(in_step_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_next_value(out_next_value), .out_next_velocity(out_next_velocity),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint wide_sat(longint v);
    if (v > cds_pkg::WideMax) return cds_pkg::WideMax;
    if (v < -cds_pkg::WideMax) return -cds_pkg::WideMax;
    return v;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Signed Q16.16 product, truncated toward zero, wide saturated.
  function automatic longint q_mul(longint a, longint b);
    logic neg;
    logic [63:0] ua, ub, q;
    logic [127:0] full;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    full = ua * ub;
    if (full[127:64] != 0) q = cds_pkg::WideMax;
    else q = full[63:0] >> 16;
    if (q > cds_pkg::WideMax) q = cds_pkg::WideMax;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // One smoother step on the predictor state.
  function automatic smooth_result_t smooth_step(logic signed [31:0] cur_v,
                                                  logic signed [31:0] tgt_v,
                                                  logic [31:0] dt_v);
    smooth_result_t r;
    logic [63:0] st, w, x, x2, x3, den;
    longint cur, tgt, dt, vel, d, lim, err, adj, t, nv, nx;
    cur = cur_v;
    tgt = tgt_v;
    dt = {32'd0, dt_v};
    vel = velocity_q;
    st = (smooth_time_q < cds_pkg::MinSmooth) ? 64'(cds_pkg::MinSmooth)
                                              : 64'(smooth_time_q);
    w = (64'd1 << 33) / st;
    x = (w * dt) >> 16;
    if (x > cds_pkg::XLimit) x = cds_pkg::XLimit;
    x2 = (x * x) >> 16;
    x3 = (x2 * x) >> 16;
    den = 64'd65536 + x + ((cds_pkg::C048 * x2) >> 16) + ((cds_pkg::C0235 * x3) >> 16);
    d = (64'd1 << 32) / den;
    lim = ({32'd0, max_speed_q} * st) >> 16;
    err = cur - tgt;
    if (err > lim) err = lim;
    if (err < -lim) err = -lim;
    adj = cur - err;
    t = q_mul(wide_sat(vel + q_mul(w, err)), dt);
    nv = q_mul(wide_sat(vel - q_mul(w, t)), d);
    nx = wide_sat(adj + q_mul(wide_sat(err + t), d));
    if ((tgt - cur > 0) == (nx > tgt)) begin
      nx = tgt;
      nv = 0;
    end
    r.value = 32'(sat_word(nx));
    r.velocity = 32'(sat_word(nv));
    velocity_q = r.velocity;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Result checker with random receiver stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", out_next_value, 0);
        end else begin
          smooth_result_t want;
          want = pending_results.pop_front();
          if (out_next_value !== want.value)
            report_mismatch("next_value", out_next_value, want.value);
          if (out_next_velocity !== want.velocity)
            report_mismatch("next_velocity", out_next_velocity, want.velocity);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Valid stays high after an accepted item unless an idle cycle or a drain follows.
  task automatic send_item(logic signed [31:0] cur, logic signed [31:0] tgt,
                           logic [31:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_current_value <= cur;
    in_target_value <= tgt;
    in_step_time <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(smooth_step(cur, tgt, dt));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cds_pkg::RegSmoothTime) smooth_time_q = val;
    else max_speed_q = val;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h0002_0000);
      3: return -$urandom_range(32'h0002_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(32'h0000_2000);
    endcase
  endfunction

  // Extremes of the fields at reset settings, zero step and no error.
  task automatic test_directed_extremes();
    send_item(32'sd0, 32'sd0, 32'd0);
    send_item(32'sd65536, 32'sd0, 32'd1092);
    send_item(-32'sd65536, 32'sd0, 32'd1092);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd1092);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'sd100, 32'sd100, 32'd6554);
    send_item(32'sd65536, 32'sd131072, 32'd0);
    send_item(32'h7FFF_FFFF, 32'sd0, 32'hFFFF_FFFF);
    send_item(32'sd0, 32'h8000_0000, 32'd1);
    send_item(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
  endtask

  // Tiny smooth time and speed limits, including register extremes.
  task automatic test_directed_config();
    write_reg(cds_pkg::RegSmoothTime, 32'd0);
    send_item(32'sd65536, 32'sd0, 32'd1);
    send_item(32'sd65536, 32'sd0, 32'd1092);
    write_reg(cds_pkg::RegSmoothTime, 32'd6);
    send_item(-32'sd65536, 32'sd0, 32'd3);
    write_reg(cds_pkg::RegMaxSpeed, 32'd0);
    send_item(32'sd655360, 32'sd0, 32'd1092);
    write_reg(cds_pkg::RegSmoothTime, 32'hFFFF_FFFF);
    write_reg(cds_pkg::RegMaxSpeed, 32'h0001_0000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd1092);
    send_item(32'sd0, 32'sd655360, 32'hFFFF_FFFF);
    write_reg(cds_pkg::RegMaxSpeed, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd65536);
  endtask

  // Random items in runs that follow a moving target, under one setting.
  task automatic test_random_phase(int unsigned n, int unsigned idle,
                                   int unsigned stall);
    logic signed [31:0] cur, tgt;
    logic [31:0] dt;
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    if ($urandom_range(1)) write_reg(cds_pkg::RegSmoothTime, $urandom_range(32'h0004_0000));
    else write_reg(cds_pkg::RegSmoothTime, $urandom);
    if ($urandom_range(2) == 0) write_reg(cds_pkg::RegMaxSpeed, $urandom_range(32'h0010_0000));
    else write_reg(cds_pkg::RegMaxSpeed, $urandom);
    cur = rand_word();
    tgt = rand_word();
    for (int unsigned i = 0; i < n; i++) begin
      dt = rand_step();
      if ($urandom_range(9) == 0) tgt = rand_word();
      if ($urandom_range(9) == 0) cur = rand_word();
      send_item(cur, tgt, dt);
      cur = pending_results[$].value;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_directed_config();
    test_random_phase(120, 0, 0);
    test_random_phase(120, 86, 0);
    test_random_phase(120, 0, 86);
    test_random_phase(120, 21, 21);
    test_random_phase(40, 0, 0);
    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/cds_pkg.sv
hdl/cds_alu.sv
hdl/critically_damped_smoother.sv
tb/sv/critically_damped_smoother_tb.sv
